// File: hw/rtl/esgs_pkg.sv
// Shared types, widths and constants for the edge-selective Gaussian smoother.
// No dependencies; every other file of the block refers to this package by scoped names.
package esgs_pkg;

    // Line buffer depth and the counter range that bounds the effective frame width.
    localparam int MAX_WIDTH   = 1024;
    localparam int COUNT_LIMIT = 1024;
    localparam int LB_DEPTH    = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;
    localparam int LB_AW       = $clog2(LB_DEPTH);

    localparam int POS_W     = 10;
    localparam int CFG_DIM_W = 11;
    localparam int THR_W     = 21;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 21;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int NUM_CH    = 3;
    localparam int WIN_N     = 9;
    localparam int NBR_N     = 8;
    localparam int SQ_W      = 16;
    localparam int CHSUM_W   = 19;
    localparam int DSUM_W    = 21;
    localparam int ACC_W     = 12;

    // Smallest frame dimension the counters run with.
    localparam logic [CFG_DIM_W-1:0] MIN_DIM = CFG_DIM_W'(3);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH    = 11'd640;
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT   = 11'd480;
    localparam logic [THR_W-1:0]     RST_EDGE_THRESHOLD = 21'd325125;

    // 1-2-1 by 1-2-1 kernel, window in raster order, centre at index 4.
    localparam logic [2:0] GAUSS_W [WIN_N] = '{3'd1, 3'd2, 3'd1,
                                               3'd2, 3'd4, 3'd2,
                                               3'd1, 3'd2, 3'd1};
    localparam int CENTRE_IDX = 4;
    localparam int GAUSS_SH   = 4;

    typedef struct packed {
        logic [POS_W-1:0] out_x;
        logic [POS_W-1:0] out_y;
        logic             last;
    } t_meta;

    // A word held in the first pipeline stage.
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic [PIX_W-1:0] px;
        t_meta            meta;
    } t_s1;

    // Channel 0 is red in the top byte, channel 2 is blue in the bottom byte.
    function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] px, input int idx);
        return px[PIX_W-1-CH_W*idx -: CH_W];
    endfunction

endpackage

// File: hw/rtl/esgs_if.sv
// Handshake interfaces of the smoother: pixel input, result output and configuration writes.
// Depends on esgs_pkg for field widths.
interface esgs_pix_if;
    logic                          valid;
    logic                          ready;
    logic [esgs_pkg::CH_W-1:0]     red_in;
    logic [esgs_pkg::CH_W-1:0]     green_in;
    logic [esgs_pkg::CH_W-1:0]     blue_in;
    logic                          frame_start;

    modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface esgs_res_if;
    logic                          valid;
    logic                          ready;
    logic [esgs_pkg::POS_W-1:0]    out_x;
    logic [esgs_pkg::POS_W-1:0]    out_y;
    logic [esgs_pkg::CH_W-1:0]     red_out;
    logic [esgs_pkg::CH_W-1:0]     green_out;
    logic [esgs_pkg::CH_W-1:0]     blue_out;
    logic                          edge_found;
    logic                          frame_last;

    modport source (output valid, out_x, out_y, red_out, green_out, blue_out, edge_found,
                    frame_last, input ready);
    modport sink   (input valid, out_x, out_y, red_out, green_out, blue_out, edge_found,
                    frame_last, output ready);
endinterface

interface esgs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [esgs_pkg::CFG_IDX_W-1:0]    index;
    logic [esgs_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/esgs_ctrl.sv
// Input stage: position counters, frame wrap and the first pipeline register.
// Depends on esgs_pkg and the pixel interface in esgs_if.sv.
module esgs_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    esgs_pix_if.sink                           i_pix,
    input  logic [esgs_pkg::CFG_DIM_W-1:0]     i_frame_width,
    input  logic [esgs_pkg::CFG_DIM_W-1:0]     i_frame_height,
    input  logic                               i_take,
    output esgs_pkg::t_s1                      o_s1,
    output logic                               o_rd_en,
    output logic [esgs_pkg::LB_AW-1:0]         o_rd_col
);

    logic [esgs_pkg::POS_W-1:0]     r_col;
    logic [esgs_pkg::POS_W-1:0]     r_row;
    logic [esgs_pkg::POS_W-1:0]     n_col;
    logic [esgs_pkg::POS_W-1:0]     n_row;
    logic                           r_s1_v;
    logic                           r_s1_emit;
    logic [esgs_pkg::PIX_W-1:0]     r_s1_px;
    esgs_pkg::t_meta                r_s1_meta;

    logic [esgs_pkg::POS_W-1:0]     x;
    logic [esgs_pkg::POS_W-1:0]     y;
    logic [esgs_pkg::CFG_DIM_W-1:0] eff_w;
    logic [esgs_pkg::CFG_DIM_W-1:0] eff_h;
    logic [esgs_pkg::CFG_DIM_W-1:0] x_inc;
    logic [esgs_pkg::CFG_DIM_W-1:0] y_inc;
    logic                           col_wrap;
    logic                           row_wrap;
    logic                           accept;

    assign i_pix.ready = !r_s1_v || i_take;
    assign accept      = i_pix.valid && i_pix.ready;

    // Register values outside the supported range are clamped.
    always_comb begin
        if (i_frame_width < esgs_pkg::MIN_DIM) begin
            eff_w = esgs_pkg::MIN_DIM;
        end else if (i_frame_width > esgs_pkg::CFG_DIM_W'(esgs_pkg::LB_DEPTH)) begin
            eff_w = esgs_pkg::CFG_DIM_W'(esgs_pkg::LB_DEPTH);
        end else begin
            eff_w = i_frame_width;
        end
        if (i_frame_height < esgs_pkg::MIN_DIM) begin
            eff_h = esgs_pkg::MIN_DIM;
        end else if (i_frame_height > esgs_pkg::CFG_DIM_W'(esgs_pkg::COUNT_LIMIT)) begin
            eff_h = esgs_pkg::CFG_DIM_W'(esgs_pkg::COUNT_LIMIT);
        end else begin
            eff_h = i_frame_height;
        end
    end

    always_comb begin
        x        = i_pix.frame_start ? '0 : r_col;
        y        = i_pix.frame_start ? '0 : r_row;
        x_inc    = {1'b0, x} + esgs_pkg::CFG_DIM_W'(1);
        y_inc    = {1'b0, y} + esgs_pkg::CFG_DIM_W'(1);
        col_wrap = x_inc >= eff_w;
        row_wrap = y_inc >= eff_h;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : y_inc[esgs_pkg::POS_W-1:0];
        end else begin
            n_col = x_inc[esgs_pkg::POS_W-1:0];
            n_row = y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (i_take) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px         <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
            r_s1_emit       <= (x >= esgs_pkg::POS_W'(2)) && (y >= esgs_pkg::POS_W'(2));
            r_s1_meta.out_x <= x - esgs_pkg::POS_W'(1);
            r_s1_meta.out_y <= y - esgs_pkg::POS_W'(1);
            r_s1_meta.last  <= col_wrap && row_wrap;
        end
    end

    assign o_s1.valid = r_s1_v;
    assign o_s1.emit  = r_s1_emit;
    assign o_s1.px    = r_s1_px;
    assign o_s1.meta  = r_s1_meta;
    assign o_rd_en    = accept;
    assign o_rd_col   = esgs_pkg::LB_AW'(x);

    // A pixel that opens a frame sits at the top-left corner and has no window yet.
    a_start_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_pix.frame_start) |=> (r_s1_v && !r_s1_emit))
        else $error("frame start pixel marked as emitting");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !i_take) |=> (r_s1_v && $stable(r_s1_px) && $stable(r_s1_meta)))
        else $error("stalled first-stage word lost or changed");

endmodule

// File: hw/rtl/esgs_line_buf.sv
// Two line buffers holding the previous two rows, with a bypass for back-to-back
// writes and reads of the same column. Depends on esgs_pkg.
module esgs_line_buf (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [esgs_pkg::LB_AW-1:0]   i_rd_col,
    input  logic [esgs_pkg::PIX_W-1:0]   i_wr_px,
    input  logic                         i_adv,
    output logic [esgs_pkg::PIX_W-1:0]   o_up,
    output logic [esgs_pkg::PIX_W-1:0]   o_mid
);

    logic [esgs_pkg::PIX_W-1:0] r_upper  [esgs_pkg::LB_DEPTH];
    logic [esgs_pkg::PIX_W-1:0] r_middle [esgs_pkg::LB_DEPTH];
    logic [esgs_pkg::PIX_W-1:0] r_up_rd;
    logic [esgs_pkg::PIX_W-1:0] r_mid_rd;
    logic [esgs_pkg::PIX_W-1:0] r_fwd_px;
    logic [esgs_pkg::LB_AW-1:0] r_wr_col;
    logic                       r_fwd;

    // The middle row takes the new pixel at once; the old middle value moves to the
    // upper row when the word leaves the first stage.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mid_rd           <= r_middle[i_rd_col];
            r_middle[i_rd_col] <= i_wr_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_rd <= r_upper[i_rd_col];
        end
        if (i_adv) begin
            r_upper[r_wr_col] <= r_mid_rd;
        end
    end

    // Two words at the same column in a row can only come from repeated frame starts;
    // the second one must see the upper value the first one is writing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_adv && (r_wr_col == i_rd_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_px <= r_mid_rd;
            r_wr_col <= i_rd_col;
        end
    end

    assign o_up  = r_fwd ? r_fwd_px : r_up_rd;
    assign o_mid = r_mid_rd;

    a_fwd_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd) |-> $past(i_adv && i_rd_en))
        else $error("bypass selected without a colliding write");

endmodule

// File: hw/rtl/esgs_window.sv
// 3x3 pixel window: shifts in one column per word from the line buffers.
// Depends on esgs_pkg.
module esgs_window (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  esgs_pkg::t_s1                             i_s1,
    input  logic [esgs_pkg::PIX_W-1:0]                i_up,
    input  logic [esgs_pkg::PIX_W-1:0]                i_mid,
    input  logic                                      i_take,
    output logic                                      o_take,
    output logic                                      o_valid,
    output logic [esgs_pkg::WIN_N-1:0][esgs_pkg::PIX_W-1:0] o_win,
    output esgs_pkg::t_meta                           o_meta
);

    logic [esgs_pkg::WIN_N-1:0][esgs_pkg::PIX_W-1:0] r_win;
    esgs_pkg::t_meta                                 r_meta;
    logic                                            r_s2_v;
    logic                                            adv;

    assign o_take = !r_s2_v || i_take;
    assign adv    = i_s1.valid && o_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (o_take) begin
            r_s2_v <= i_s1.valid && i_s1.emit;
        end
    end

    // Every word shifts the window, also those at the border that report nothing.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3+1];
                r_win[r*3 + 1] <= r_win[r*3+2];
            end
            r_win[2] <= i_up;
            r_win[5] <= i_mid;
            r_win[8] <= i_s1.px;
            r_meta   <= i_s1.meta;
        end
    end

    assign o_valid = r_s2_v;
    assign o_win   = r_win;
    assign o_meta  = r_meta;

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s2_v) |-> $past(i_s1.valid && i_s1.emit && o_take))
        else $error("window stage valid without an emitting word");

endmodule

// File: hw/rtl/esgs_filter.sv
// Edge test and Gaussian average: squares, per-channel sums, then the threshold
// compare into the result register. Depends on esgs_pkg and esgs_res_if.
module esgs_filter (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    input  logic [esgs_pkg::WIN_N-1:0][esgs_pkg::PIX_W-1:0] i_win,
    input  esgs_pkg::t_meta                                 i_meta,
    input  logic [esgs_pkg::THR_W-1:0]                      i_threshold,
    output logic                                            o_take,
    esgs_res_if.source                                      o_res
);

    // Square stage
    logic                                                              r_s3_v;
    logic [esgs_pkg::NUM_CH-1:0][esgs_pkg::NBR_N-1:0][esgs_pkg::SQ_W-1:0] r_sq;
    logic [esgs_pkg::NUM_CH-1:0][esgs_pkg::ACC_W-1:0]                  r_acc3;
    logic [esgs_pkg::PIX_W-1:0]                                        r_ctr3;
    esgs_pkg::t_meta                                                   r_meta3;
    logic [esgs_pkg::NUM_CH-1:0][esgs_pkg::NBR_N-1:0][esgs_pkg::SQ_W-1:0] n_sq;
    logic [esgs_pkg::NUM_CH-1:0][esgs_pkg::ACC_W-1:0]                  n_acc;

    // Channel sum stage
    logic                                                r_s4_v;
    logic [esgs_pkg::NUM_CH-1:0][esgs_pkg::CHSUM_W-1:0]  r_chsum;
    logic [esgs_pkg::NUM_CH-1:0][esgs_pkg::ACC_W-1:0]    r_acc4;
    logic [esgs_pkg::PIX_W-1:0]                          r_ctr4;
    esgs_pkg::t_meta                                     r_meta4;
    logic [esgs_pkg::NUM_CH-1:0][esgs_pkg::CHSUM_W-1:0]  n_chsum;

    // Result register
    logic                        r_out_v;
    logic [esgs_pkg::POS_W-1:0]  r_out_x;
    logic [esgs_pkg::POS_W-1:0]  r_out_y;
    logic [esgs_pkg::PIX_W-1:0]  r_out_px;
    logic                        r_out_edge;
    logic                        r_out_last;
    logic [esgs_pkg::DSUM_W-1:0] dsum;
    logic                        edge_hit;
    logic [esgs_pkg::PIX_W-1:0]  smooth_px;

    logic en_out;
    logic en4;

    assign en_out = !r_out_v || o_res.ready;
    assign en4    = !r_s4_v || en_out;
    assign o_take = !r_s3_v || en4;

    // Absolute differences against the centre, squared, and the weighted channel sums.
    always_comb begin
        logic [esgs_pkg::CH_W-1:0] a;
        logic [esgs_pkg::CH_W-1:0] b;
        logic [esgs_pkg::CH_W-1:0] d;
        int                        k;
        for (int c = 0; c < esgs_pkg::NUM_CH; c++) begin
            b = esgs_pkg::chan(i_win[esgs_pkg::CENTRE_IDX], c);
            for (int j = 0; j < esgs_pkg::NBR_N; j++) begin
                k = (j < esgs_pkg::CENTRE_IDX) ? j : j + 1;
                a = esgs_pkg::chan(i_win[k], c);
                d = (a >= b) ? a - b : b - a;
                n_sq[c][j] = esgs_pkg::SQ_W'(d) * esgs_pkg::SQ_W'(d);
            end
            n_acc[c] = '0;
            for (int m = 0; m < esgs_pkg::WIN_N; m++) begin
                n_acc[c] = n_acc[c] + esgs_pkg::ACC_W'(esgs_pkg::GAUSS_W[m])
                                    * esgs_pkg::ACC_W'(esgs_pkg::chan(i_win[m], c));
            end
        end
    end

    always_comb begin
        for (int c = 0; c < esgs_pkg::NUM_CH; c++) begin
            n_chsum[c] = '0;
            for (int j = 0; j < esgs_pkg::NBR_N; j++) begin
                n_chsum[c] = n_chsum[c] + esgs_pkg::CHSUM_W'(r_sq[c][j]);
            end
        end
    end

    always_comb begin
        dsum = esgs_pkg::DSUM_W'(r_chsum[0]) + esgs_pkg::DSUM_W'(r_chsum[1])
             + esgs_pkg::DSUM_W'(r_chsum[2]);
        edge_hit = dsum > i_threshold;
        for (int c = 0; c < esgs_pkg::NUM_CH; c++) begin
            smooth_px[esgs_pkg::PIX_W-1-esgs_pkg::CH_W*c -: esgs_pkg::CH_W] =
                r_acc4[c][esgs_pkg::GAUSS_SH +: esgs_pkg::CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_take) begin
                r_s3_v <= i_valid;
            end
            if (en4) begin
                r_s4_v <= r_s3_v;
            end
            if (en_out) begin
                r_out_v <= r_s4_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_sq    <= n_sq;
            r_acc3  <= n_acc;
            r_ctr3  <= i_win[esgs_pkg::CENTRE_IDX];
            r_meta3 <= i_meta;
        end
        if (en4 && r_s3_v) begin
            r_chsum <= n_chsum;
            r_acc4  <= r_acc3;
            r_ctr4  <= r_ctr3;
            r_meta4 <= r_meta3;
        end
        if (en_out && r_s4_v) begin
            r_out_x    <= r_meta4.out_x;
            r_out_y    <= r_meta4.out_y;
            r_out_last <= r_meta4.last;
            r_out_edge <= edge_hit;
            r_out_px   <= edge_hit ? smooth_px : r_ctr4;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.out_x      = r_out_x;
    assign o_res.out_y      = r_out_y;
    assign o_res.red_out    = esgs_pkg::chan(r_out_px, 0);
    assign o_res.green_out  = esgs_pkg::chan(r_out_px, 1);
    assign o_res.blue_out   = esgs_pkg::chan(r_out_px, 2);
    assign o_res.edge_found = r_out_edge;
    assign o_res.frame_last = r_out_last;

    a_no_drop_s4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_v && r_out_v && !o_res.ready) |=> (r_s4_v && $stable(r_chsum)))
        else $error("sum stage word dropped while the result was stalled");

endmodule

// File: hw/rtl/edge_selective_gaussian_smoother.sv
// Top level of the edge-selective 3x3 Gaussian smoother: configuration registers and
// the pipeline. Depends on esgs_pkg, esgs_if.sv, esgs_ctrl, esgs_line_buf, esgs_window, esgs_filter.
//
// The block takes one RGB888 pixel word per clock in raster order while the pipeline is not held
// by a stalled output, and returns one result word for each interior pixel, with its column and
// row, either the 1-2-1 Gaussian average (when the summed squared channel differences to the eight
// neighbours exceed edge_threshold) or the original pixel. Border pixels give no result. A pixel
// passes the first-stage register, the window register, the square and channel-sum stages and the
// result register; throughput is one pixel per cycle while the output is not stalled, set by the
// single read and write of each line buffer per pixel, and a stalled output only holds the input back
// once the pipeline is full. frame_start restarts the position counters; otherwise a new frame starts
// after frame_height rows. Configuration is written through its own channel, which is always ready,
// and must only change while the pipeline is empty. The line buffers need no clearing after reset.
module edge_selective_gaussian_smoother (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esgs_pix_if.sink   i_pix,
    esgs_cfg_if.sink   i_cfg,
    esgs_res_if.source o_res
);

    logic [esgs_pkg::CFG_DIM_W-1:0] r_frame_width;
    logic [esgs_pkg::CFG_DIM_W-1:0] r_frame_height;
    logic [esgs_pkg::THR_W-1:0]     r_edge_threshold;

    esgs_pkg::t_s1                                   s1;
    esgs_pkg::t_meta                                 win_meta;
    logic [esgs_pkg::WIN_N-1:0][esgs_pkg::PIX_W-1:0] win;
    logic [esgs_pkg::LB_AW-1:0]                      rd_col;
    logic [esgs_pkg::PIX_W-1:0]                      up_px;
    logic [esgs_pkg::PIX_W-1:0]                      mid_px;
    logic                                            rd_en;
    logic                                            s1_take;
    logic                                            win_take;
    logic                                            win_valid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= esgs_pkg::RST_FRAME_WIDTH;
            r_frame_height   <= esgs_pkg::RST_FRAME_HEIGHT;
            r_edge_threshold <= esgs_pkg::RST_EDGE_THRESHOLD;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                esgs_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg.data[esgs_pkg::CFG_DIM_W-1:0];
                end
                esgs_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg.data[esgs_pkg::CFG_DIM_W-1:0];
                end
                esgs_pkg::CFG_EDGE_THRESHOLD: begin
                    r_edge_threshold <= i_cfg.data[esgs_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    esgs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix          (i_pix),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_take         (s1_take),
        .o_s1           (s1),
        .o_rd_en        (rd_en),
        .o_rd_col       (rd_col)
    );

    esgs_line_buf u_line_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (rd_en),
        .i_rd_col (rd_col),
        .i_wr_px  ({i_pix.red_in, i_pix.green_in, i_pix.blue_in}),
        .i_adv    (s1.valid && s1_take),
        .o_up     (up_px),
        .o_mid    (mid_px)
    );

    esgs_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .i_up    (up_px),
        .i_mid   (mid_px),
        .i_take  (win_take),
        .o_take  (s1_take),
        .o_valid (win_valid),
        .o_win   (win),
        .o_meta  (win_meta)
    );

    esgs_filter u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (win_valid),
        .i_win       (win),
        .i_meta      (win_meta),
        .i_threshold (r_edge_threshold),
        .o_take      (win_take),
        .o_res       (o_res)
    );

endmodule
